### design/ppps_pkg.sv
// Shared types and constants of the pentagon prism particle selector.
// Used by every module of the block; depends on nothing.

package ppps_pkg;

  // configuration port
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Y = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE_Z = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUND_RSQ = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_THICK = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CIRC_RADIUS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE = 4'd7;

  // pentagon constants, Q.16
  localparam int K_D_INT1 = 55748;
  localparam int K_SLOPE1 = 21294;
  localparam int K_SLOPE2 = 90203;
  localparam int K_SIN54 = 53020;
  localparam int K_COS72 = 20252;

  // datapath widths
  localparam int CW = 24;        // centre, thickness, radius
  localparam int TYPE_W = 8;
  localparam int BRSQ_W = 48;
  localparam int TW = 16;        // Q1.14 trig term
  localparam int RW = 18;        // rounded product term
  localparam int HTW = 38;       // half thickness at raw * 2^14
  localparam int DCW = 55;       // circumradius terms at raw * 2^30
  localparam int DQW = 25;       // position difference once in range
  localparam int SQW = 48;       // one squared difference
  localparam int RSQW = 50;      // squared distance
  localparam int PRW = 43;       // rounded term times difference
  localparam int PTW = 41;       // trig term times difference
  localparam int DX1W = 43;
  localparam int DY1W = 42;
  localparam int DZ1W = 43;
  localparam int EW = 60;        // in-plane comparisons at raw * 2^30

  localparam logic signed [EW-1:0] K_SLOPE1_E = EW'(K_SLOPE1);
  localparam logic signed [EW-1:0] K_SLOPE2_E = EW'(K_SLOPE2);

  // queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW = 2;

  typedef struct packed {
    logic [CW-1:0] centre_x;
    logic [CW-1:0] centre_y;
    logic [CW-1:0] centre_z;
    logic [TYPE_W-1:0] wanted_type;
    logic [BRSQ_W-1:0] bound_radius_sq;
    logic [HTW-1:0] ht14;
    logic signed [TW-1:0] ct;
    logic signed [TW-1:0] st;
    logic signed [TW-1:0] cp;
    logic signed [TW-1:0] sp;
    logic signed [RW-1:0] r00;
    logic signed [RW-1:0] r01;
    logic signed [RW-1:0] r20;
    logic signed [RW-1:0] r21;
    logic [DCW-1:0] d_lo;
    logic [DCW-1:0] d_mid;
    logic [DCW-1:0] d_top;
    logic [DCW-1:0] d_e1;
    logic [DCW-1:0] d_e2;
  } cfg_t;

  typedef struct packed {
    logic live;
    logic signed [DQW-1:0] dx;
    logic signed [DQW-1:0] dy;
    logic signed [DQW-1:0] dz;
  } q_entry_t;

endpackage

### design/ppps_cfg.sv
// Configuration registers and the terms derived from them.
// Depends on ppps_pkg; derived terms are registered from the written values.

module ppps_cfg import ppps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CW-1:0] centre_x_r, centre_y_r, centre_z_r;
  logic [63:0] trig_r;
  logic [BRSQ_W-1:0] brsq_r;
  logic [CW-1:0] half_thick_r, circ_r;
  logic [TYPE_W-1:0] wanted_type_r;

  logic signed [RW-1:0] r00_r, r01_r, r20_r, r21_r;
  logic signed [RW-1:0] r00_nxt, r01_nxt, r20_nxt, r21_nxt;
  logic [DCW-1:0] d_lo_r, d_mid_r, d_top_r, d_e1_r, d_e2_r;

  logic signed [TW-1:0] ct, st, cp, sp;
  logic signed [2*TW-1:0] m00, m01, m20, m21;
  logic signed [2*TW:0] t00, t01, t20, t21;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      centre_x_r <= '0;
      centre_y_r <= '0;
      centre_z_r <= '0;
      trig_r <= '0;
      brsq_r <= '0;
      half_thick_r <= '0;
      circ_r <= '0;
      wanted_type_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CENTRE_X:    centre_x_r <= cfg_data[CW-1:0];
        CFG_CENTRE_Y:    centre_y_r <= cfg_data[CW-1:0];
        CFG_CENTRE_Z:    centre_z_r <= cfg_data[CW-1:0];
        CFG_TRIG:        trig_r <= cfg_data;
        CFG_BOUND_RSQ:   brsq_r <= cfg_data[BRSQ_W-1:0];
        CFG_HALF_THICK:  half_thick_r <= cfg_data[CW-1:0];
        CFG_CIRC_RADIUS: circ_r <= cfg_data[CW-1:0];
        CFG_WANTED_TYPE: wanted_type_r <= cfg_data[TYPE_W-1:0];
        default: ;
      endcase
    end
  end

  assign ct = trig_r[15:0];
  assign st = trig_r[31:16];
  assign cp = trig_r[47:32];
  assign sp = trig_r[63:48];

  // Q.28 products rounded half up to Q.14
  assign m00 = (2*TW)'(ct) * (2*TW)'(cp);
  assign m01 = (2*TW)'(ct) * (2*TW)'(sp);
  assign m20 = (2*TW)'(st) * (2*TW)'(cp);
  assign m21 = (2*TW)'(st) * (2*TW)'(sp);
  assign t00 = (2*TW+1)'(m00) + (2*TW+1)'(8192);
  assign t01 = (2*TW+1)'(m01) + (2*TW+1)'(8192);
  assign t20 = (2*TW+1)'(m20) + (2*TW+1)'(8192);
  assign t21 = (2*TW+1)'(m21) + (2*TW+1)'(8192);
  assign r00_nxt = t00[2*TW-1:14];
  assign r01_nxt = t01[2*TW-1:14];
  assign r20_nxt = t20[2*TW-1:14];
  assign r21_nxt = t21[2*TW-1:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r00_r <= '0;
      r01_r <= '0;
      r20_r <= '0;
      r21_r <= '0;
      d_lo_r <= '0;
      d_mid_r <= '0;
      d_top_r <= '0;
      d_e1_r <= '0;
      d_e2_r <= '0;
    end else begin
      r00_r <= r00_nxt;
      r01_r <= r01_nxt;
      r20_r <= r20_nxt;
      r21_r <= r21_nxt;
      d_lo_r <= (DCW'(circ_r) * DCW'(K_SIN54)) << 14;
      d_mid_r <= (DCW'(circ_r) * DCW'(K_COS72)) << 14;
      d_top_r <= DCW'(circ_r) << 30;
      d_e1_r <= (DCW'(circ_r) * DCW'(K_D_INT1)) << 14;
      d_e2_r <= (DCW'(circ_r) * DCW'(K_SLOPE2)) << 14;
    end
  end

  always_comb begin
    cfg.centre_x = centre_x_r;
    cfg.centre_y = centre_y_r;
    cfg.centre_z = centre_z_r;
    cfg.wanted_type = wanted_type_r;
    cfg.bound_radius_sq = brsq_r;
    cfg.ht14 = {half_thick_r, 14'b0};
    cfg.ct = ct;
    cfg.st = st;
    cfg.cp = cp;
    cfg.sp = sp;
    cfg.r00 = r00_r;
    cfg.r01 = r01_r;
    cfg.r20 = r20_r;
    cfg.r21 = r21_r;
    cfg.d_lo = d_lo_r;
    cfg.d_mid = d_mid_r;
    cfg.d_top = d_top_r;
    cfg.d_e1 = d_e1_r;
    cfg.d_e2 = d_e2_r;
  end

endmodule

### design/ppps_front.sv
// Front end: takes a particle beat, forms the offsets from the centre and
// marks particles that fail the type or range test. Depends on ppps_pkg.

module ppps_front import ppps_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [COORD_BITS-1:0] in_pos_z,
  input  logic [TYPE_W-1:0]     in_particle_type,
  output logic                  push_valid,
  input  logic                  push_ready,
  output q_entry_t              push_entry
);

  localparam int DW = ((COORD_BITS > CW) ? COORD_BITS : CW) + 2;
  localparam logic signed [DW-1:0] LIM = DW'(1) << CW;
  localparam logic signed [DW-1:0] NEG_LIM = -LIM;

  logic f_valid_r;
  logic [COORD_BITS-1:0] pos_x_r, pos_y_r, pos_z_r;
  logic [TYPE_W-1:0] type_r;

  logic signed [DW-1:0] dx, dy, dz;
  logic far_x, far_y, far_z;

  assign in_ready = !f_valid_r || push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (in_ready) begin
      f_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_x_r <= in_pos_x;
      pos_y_r <= in_pos_y;
      pos_z_r <= in_pos_z;
      type_r <= in_particle_type;
    end
  end

  assign dx = $signed({1'b0, (DW-1)'(pos_x_r)}) - $signed({1'b0, (DW-1)'(cfg.centre_x)});
  assign dy = $signed({1'b0, (DW-1)'(pos_y_r)}) - $signed({1'b0, (DW-1)'(cfg.centre_y)});
  assign dz = $signed({1'b0, (DW-1)'(pos_z_r)}) - $signed({1'b0, (DW-1)'(cfg.centre_z)});

  // outside every sphere the radius register can express
  assign far_x = (dx >= LIM) || (dx <= NEG_LIM);
  assign far_y = (dy >= LIM) || (dy <= NEG_LIM);
  assign far_z = (dz >= LIM) || (dz <= NEG_LIM);

  assign push_valid = f_valid_r;

  always_comb begin
    push_entry.live = (type_r == cfg.wanted_type) && !far_x && !far_y && !far_z;
    push_entry.dx = dx[DQW-1:0];
    push_entry.dy = dy[DQW-1:0];
    push_entry.dz = dz[DQW-1:0];
  end

endmodule

### design/ppps_queue.sv
// Short queue that decouples the front end from the back-end pipeline.
// Depends on ppps_pkg for the entry type and depth.

module ppps_queue import ppps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_entry,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_entry
);

  q_entry_t slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_AW:0] count_r, count_nxt;
  logic push, pop;

  assign push_ready = (count_r != (Q_AW+1)'(Q_DEPTH));
  assign pop_valid = (count_r != '0);
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_entry = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue fill count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != (Q_AW+1)'(Q_DEPTH)) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with fill count");

endmodule

### design/ppps_back.sv
// Back-end pipeline: squared distance, rotation into the pentagon frame,
// slab and pentagon tests, output register. Depends on ppps_pkg.

module ppps_back import ppps_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     pop_valid,
  output logic     pop_ready,
  input  q_entry_t pop_entry,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_selected
);

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // stage 1
  q_entry_t s1_r;

  // stage 2: products
  logic live2_r;
  logic [SQW-1:0] sqx_r, sqy_r, sqz_r;
  logic signed [PRW-1:0] p00_r, p01_r, p20_r, p21_r;
  logic signed [PTW-1:0] pst_r, psx_r, pcy_r, pcz_r;
  logic signed [2*DQW-1:0] fsqx, fsqy, fsqz;

  // stage 3: sums
  logic live3_r;
  logic [RSQW-1:0] rsq_r;
  logic signed [DX1W-1:0] dx1_r;
  logic signed [DY1W-1:0] dy1_r;
  logic signed [DZ1W-1:0] dz1_r;

  // stage 4: tests
  logic ok4_r, band1_r, band2_r;
  logic signed [EW-1:0] x30_r, edge1_r, edge2_r;
  logic sphere, slab;
  logic [DZ1W-1:0] adz;
  logic [DX1W-1:0] adx;
  logic signed [DZ1W-1:0] neg_dz1;
  logic signed [DX1W-1:0] neg_dx1;
  logic signed [EW-1:0] y_e, y30, lo_e, mid_e, top_e, e1_e, e2_e;

  // stage 5: result
  logic sel5_r;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign pop_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= pop_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_r <= pop_entry;
    end
  end

  assign fsqx = (2*DQW)'(s1_r.dx) * (2*DQW)'(s1_r.dx);
  assign fsqy = (2*DQW)'(s1_r.dy) * (2*DQW)'(s1_r.dy);
  assign fsqz = (2*DQW)'(s1_r.dz) * (2*DQW)'(s1_r.dz);

  always_ff @(posedge clk) begin
    if (rdy2) begin
      live2_r <= s1_r.live;
      sqx_r <= fsqx[SQW-1:0];
      sqy_r <= fsqy[SQW-1:0];
      sqz_r <= fsqz[SQW-1:0];
      p00_r <= PRW'(s1_r.dx) * PRW'(cfg.r00);
      p01_r <= PRW'(s1_r.dy) * PRW'(cfg.r01);
      p20_r <= PRW'(s1_r.dx) * PRW'(cfg.r20);
      p21_r <= PRW'(s1_r.dy) * PRW'(cfg.r21);
      pst_r <= PTW'(s1_r.dz) * PTW'(cfg.st);
      psx_r <= PTW'(s1_r.dx) * PTW'(cfg.sp);
      pcy_r <= PTW'(s1_r.dy) * PTW'(cfg.cp);
      pcz_r <= PTW'(s1_r.dz) * PTW'(cfg.ct);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      live3_r <= live2_r;
      rsq_r <= RSQW'(sqx_r) + RSQW'(sqy_r) + RSQW'(sqz_r);
      dx1_r <= DX1W'(p00_r) + DX1W'(p01_r) - DX1W'(pst_r);
      dy1_r <= DY1W'(pcy_r) - DY1W'(psx_r);
      dz1_r <= DZ1W'(p20_r) + DZ1W'(p21_r) + DZ1W'(pcz_r);
    end
  end

  assign sphere = rsq_r < RSQW'(cfg.bound_radius_sq);
  assign neg_dz1 = -dz1_r;
  assign neg_dx1 = -dx1_r;
  assign adz = dz1_r[DZ1W-1] ? neg_dz1 : dz1_r;
  assign adx = dx1_r[DX1W-1] ? neg_dx1 : dx1_r;
  assign slab = adz < DZ1W'(cfg.ht14);

  assign y_e = EW'(dy1_r);
  assign y30 = y_e <<< 16;
  assign lo_e = $signed(EW'(cfg.d_lo));
  assign mid_e = $signed(EW'(cfg.d_mid));
  assign top_e = $signed(EW'(cfg.d_top));
  assign e1_e = $signed(EW'(cfg.d_e1));
  assign e2_e = $signed(EW'(cfg.d_e2));

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ok4_r <= live3_r && sphere && slab;
      // the 0.309017 d line itself belongs to neither band
      band1_r <= (y30 > -lo_e) && (y30 < mid_e);
      band2_r <= (y30 > mid_e) && (y30 < top_e);
      x30_r <= $signed(EW'(adx)) <<< 16;
      edge1_r <= y_e * K_SLOPE1_E + e1_e;
      edge2_r <= e2_e - y_e * K_SLOPE2_E;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      sel5_r <= ok4_r && ((band1_r && (x30_r < edge1_r)) ||
                          (band2_r && (x30_r < edge2_r)));
    end
  end

  assign out_valid = v5_r;
  assign out_selected = sel5_r;

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && v5_r && !out_ready) |=> (v4_r && v5_r))
    else $error("back pipeline lost a beat under stall");

  a_pop_gated: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && !rdy2) |-> !pop_ready)
    else $error("pop taken while stage one is held");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_selected)))
    else $error("result beat changed while stalled");

endmodule

### design/pentagon_prism_particle_select_core.sv
// Top level of the pentagon prism particle selector.
// Depends on ppps_pkg, ppps_cfg, ppps_front, ppps_queue and ppps_back.

// One particle is taken per cycle unless the output stalls, and one selected
// flag comes back for each, in order; out_valid follows the beat through the
// input register, one queue slot and five back-end stages, output register last.
// The sustained rate of one per cycle is set by the back-end pipeline, which
// forms all its products in parallel within stages 2 and 4; the queue lets the
// front keep taking beats while the output is stalled, until its four slots are
// full. Configuration writes are taken at any time with cfg_ready high; rotation
// and pentagon terms derived from them are registered from the written values.

module pentagon_prism_particle_select_core import ppps_pkg::*; #(
  parameter int COORD_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_BITS-1:0] in_pos_x,
  input  logic [COORD_BITS-1:0] in_pos_y,
  input  logic [COORD_BITS-1:0] in_pos_z,
  input  logic [TYPE_W-1:0]     in_particle_type,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_selected
);

  cfg_t cfg;
  logic push_valid, push_ready, pop_valid, pop_ready;
  q_entry_t push_entry, pop_entry;

  ppps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ppps_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_particle_type (in_particle_type),
    .push_valid       (push_valid),
    .push_ready       (push_ready),
    .push_entry       (push_entry)
  );

  ppps_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  ppps_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_entry    (pop_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_selected (out_selected)
  );

endmodule
